FILE: design/fmtone_pkg.sv
// ============================================================================
// fmtone_pkg
// Shared types, codes and constants for the FM channel tone register block.
// ============================================================================
`default_nettype none

package fmtone_pkg;

    // Fixed geometry
    localparam int NUM_CH     = 9;
    localparam int REG_DEPTH  = 64;
    localparam int REG_AW     = 6;
    localparam int CH_W       = 4;
    localparam int DRUM_FIRST = 6;

    // Register map
    localparam logic [REG_AW-1:0] REG_RHYTHM = 6'h0E;
    localparam logic [REG_AW-1:0] PAIR_FLIP  = 6'h30;
    localparam logic [1:0] GRP_CTRL = 2'd0;
    localparam logic [1:0] GRP_FLO  = 2'd1;
    localparam logic [1:0] GRP_FHI  = 2'd2;
    localparam logic [1:0] GRP_VOL  = 2'd3;
    localparam logic [3:0] CH_LAST  = 4'd8;
    localparam logic [3:0] CH_RHYTHM = 4'hE;

    // Sync command modes
    localparam logic [1:0] SYNC_ASYNC = 2'd0;
    localparam logic [1:0] SYNC_KEEP  = 2'd2;

    // Tone math
    localparam logic [20:0] TONE_MULT = 21'd3125;
    localparam logic [7:0]  ATT_INIT  = 8'h0F;

    typedef enum logic [1:0] {
        OP_LATCH  = 2'd0,
        OP_DATA   = 2'd1,
        OP_DIRECT = 2'd2,
        OP_SYNC   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_EXEC,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  reg_address;
        logic [7:0]  write_value;
        logic [1:0]  sync_mode;
    } t_in_item;

    typedef struct packed {
        logic [8:0]  sound_channel;
        logic [12:0] tone_frequency;
        logic [7:0]  tone_volume;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic rd_b;
        logic exec;
        logic start_flush;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic exec_flush;
        logic pend_nz;
        logic out_free;
    } t_stat;

    // Value of a register file entry that was never written
    function automatic logic [7:0] reg_reset_value(input logic [REG_AW-1:0] addr);
        if (addr[5:4] == GRP_VOL && addr[3:0] <= CH_LAST) begin
            return ATT_INIT;
        end
        return 8'h00;
    endfunction

endpackage

`default_nettype wire

FILE: design/fmtone_ctrl.sv
// ============================================================================
// fmtone_ctrl
// Sequencer: accepts a request, steps the register read, update and the
// per-channel report walk.
// ============================================================================
`default_nettype none

module fmtone_ctrl
    import fmtone_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_opcode i_opcode,
    input  wire t_stat   i_stat,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_opcode)
                        OP_LATCH: n_state = ST_IDLE;
                        OP_SYNC: begin
                            o_cmd.start_flush = 1'b1;
                            n_state = ST_FLUSH;
                        end
                        default: n_state = ST_RD_A;
                    endcase
                end
            end
            ST_RD_A: n_state = ST_RD_B;
            ST_RD_B: begin
                o_cmd.rd_b = 1'b1;
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.exec_flush) begin
                    o_cmd.start_flush = 1'b1;
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (i_stat.pend_nz) begin
                    o_cmd.emit = i_stat.out_free;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/fmtone_dp.sv
// ============================================================================
// fmtone_dp
// Datapath: register file, per-channel tone and volume, change mask and the
// output register for channel reports.
// ============================================================================
`default_nettype none

module fmtone_dp
    import fmtone_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_in_data,
    input  wire logic     i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire t_cmd     i_cmd,
    output t_stat         o_stat,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    // Control and small state
    logic [REG_AW-1:0] r_latch;
    logic              r_sync;
    logic [7:0]        r_first;
    logic [7:0]        r_reg0e;
    logic [NUM_CH-1:0] r_mask, r_pend;
    logic              r_ovalid;
    logic [12:0]       r_freq [NUM_CH];
    logic [7:0]        r_vol  [NUM_CH];

    // Request payload
    logic [REG_AW-1:0] r_a;
    logic [7:0]        r_val;
    logic [7:0]        r_cur;

    // Register file memory with per-entry valid bits
    logic [7:0]           mem [REG_DEPTH];
    logic [REG_DEPTH-1:0] r_valid;
    logic [7:0]           r_rd_data;
    logic                 r_rd_vld;
    logic [REG_AW-1:0]    r_rd_addr;
    logic [REG_AW-1:0]    rd_addr;
    logic [7:0]           eff;

    // Update decode
    logic [3:0]        c;
    logic              drums;
    logic              ok, set_freq, set_vol, mute_drums;
    logic [7:0]        store, tone_hi, tone_lo;
    logic [12:0]       freq_val, tone;
    logic [NUM_CH-1:0] add_mask, n_mask;
    logic [8:0]        fnum;
    logic [20:0]       prod;
    logic [27:0]       wide;

    // Report walk
    logic [CH_W-1:0]   sel_idx;
    logic [NUM_CH-1:0] sel_bit;

    // Capture request and handle latch / sync mode
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a   <= (i_in_data.opcode == OP_DATA) ? r_latch : i_in_data.reg_address[5:0];
            r_val <= i_in_data.write_value;
        end
        if (i_cmd.rd_b) begin
            r_cur <= (r_a == REG_RHYTHM) ? r_reg0e : eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
            r_sync  <= 1'b0;
            r_first <= '0;
        end else begin
            if (i_cfg_we) begin
                r_first <= i_cfg_data;
            end
            if (i_cmd.accept && i_in_data.opcode == OP_LATCH) begin
                r_latch <= i_in_data.write_value[5:0];
            end
            if (i_cmd.accept && i_in_data.opcode == OP_SYNC &&
                i_in_data.sync_mode != SYNC_KEEP) begin
                r_sync <= (i_in_data.sync_mode != SYNC_ASYNC);
            end
        end
    end

    // Register file: one read per cycle, write on a stored update
    assign rd_addr = i_cmd.rd_b ? (r_a ^ PAIR_FLIP) : r_a;

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
        r_rd_addr <= rd_addr;
        if (i_cmd.exec && ok) begin
            mem[r_a] <= store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[rd_addr];
            if (i_cmd.exec && ok) begin
                r_valid[r_a] <= 1'b1;
            end
        end
    end

    assign eff = r_rd_vld ? r_rd_data : reg_reset_value(r_rd_addr);

    // Tone: (3125 * fnum << block) >> 15
    assign fnum = {tone_hi[0], tone_lo};
    assign prod = 21'(fnum) * TONE_MULT;
    assign wide = 28'(prod) << tone_hi[3:1];
    assign tone = wide[27:15];

    // Update decode, partner entry arrives in eff during exec
    assign c     = r_a[3:0];
    assign drums = r_reg0e[5];

    always_comb begin
        ok         = 1'b0;
        store      = r_val;
        tone_hi    = eff;
        tone_lo    = r_val;
        freq_val   = tone;
        set_freq   = 1'b0;
        set_vol    = 1'b0;
        mute_drums = 1'b0;
        case (r_a[5:4])
            GRP_CTRL: begin
                if (c == CH_RHYTHM) begin
                    if (r_val != r_cur) begin
                        ok    = 1'b1;
                        store = r_val[5] ? r_val : (r_val & 8'hE0);
                        mute_drums = ((store ^ r_cur) & store & 8'h20) != 8'h00;
                    end
                end else begin
                    ok = 1'b1;
                end
            end
            GRP_FLO: begin
                if (c <= CH_LAST && r_val != r_cur) begin
                    ok = 1'b1;
                    set_freq = (!drums || c < 4'(DRUM_FIRST)) && eff[4];
                end
            end
            GRP_FHI: begin
                if (c <= CH_LAST) begin
                    ok       = 1'b1;
                    tone_hi  = r_val;
                    tone_lo  = eff;
                    freq_val = r_val[4] ? tone : 13'd0;
                    set_freq = !drums || c < 4'(DRUM_FIRST);
                end
            end
            default: begin
                if (c <= CH_LAST && r_val != r_cur) begin
                    ok = 1'b1;
                    set_vol = (r_val[3:0] ^ r_cur[3:0]) != 4'd0;
                end
            end
        endcase
    end

    // Change mask gathered this cycle
    always_comb begin
        add_mask = '0;
        if (i_cmd.exec) begin
            if (set_freq || set_vol) begin
                add_mask = NUM_CH'(1) << c;
            end
            if (mute_drums) begin
                for (int j = DRUM_FIRST; j < NUM_CH; j++) begin
                    add_mask[j] = 1'b1;
                end
            end
        end
    end

    assign n_mask = r_mask | add_mask;

    // Channel state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_CH; j++) begin
                r_freq[j] <= '0;
                r_vol[j]  <= '0;
            end
            r_reg0e <= '0;
        end else if (i_cmd.exec) begin
            if (set_freq) begin
                r_freq[c] <= freq_val;
            end
            if (set_vol) begin
                r_vol[c] <= {~r_val[3:0], ~r_val[3:0]};
            end
            if (mute_drums) begin
                for (int j = DRUM_FIRST; j < NUM_CH; j++) begin
                    r_freq[j] <= '0;
                end
            end
            if (ok && r_a == REG_RHYTHM) begin
                r_reg0e <= store;
            end
        end
    end

    // Lowest pending channel
    always_comb begin
        sel_idx = '0;
        for (int j = NUM_CH - 1; j >= 0; j--) begin
            if (r_pend[j]) begin
                sel_idx = CH_W'(j);
            end
        end
    end

    assign sel_bit = NUM_CH'(1) << sel_idx;

    // Mask and pending walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '1;
            r_pend <= '0;
        end else if (i_cmd.start_flush) begin
            r_mask <= '0;
            r_pend <= n_mask;
        end else begin
            r_mask <= n_mask;
            if (i_cmd.emit) begin
                r_pend <= r_pend & ~sel_bit;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_data.sound_channel  <= 9'(r_first) + 9'(sel_idx);
            o_out_data.tone_frequency <= r_freq[sel_idx];
            o_out_data.tone_volume    <= r_vol[sel_idx];
            o_out_data.last_of_run    <= (r_pend & ~sel_bit) == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_stat.exec_flush = i_cmd.exec && ok && !r_sync && (n_mask != '0);
    assign o_stat.pend_nz    = r_pend != '0;
    assign o_stat.out_free   = !r_ovalid || i_out_ready;

endmodule

`default_nettype wire

FILE: design/fm_sound_register_to_channel_tone.sv
// ============================================================================
// fm_sound_register_to_channel_tone
// Register front end of a nine-channel FM sound block with channel reports.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries bus requests:
//   address latch write, data port write, direct register write, sync/flush.
//   Output channel (o_out_valid / i_out_ready / o_out_data) carries one
//   report per changed channel, lowest channel first, last_of_run on the end.
//   i_cfg_we / i_cfg_data set the channel number offset; write it while idle.
// Sequence:
//   A latch write is taken on accept alone. A register write steps through
//   accept, two reads of the register file (the entry, then its partner)
//   and the update. A flush then emits one report per changed channel and
//   finishes; the walk emits one channel per cycle while the output is free.
// Reset (i_rst_n low, synchronous): async mode, latch cleared, all nine
//   channels marked changed, register file reads its power-on values.
// Stall: a report waits in the output register; the walk pauses while it is
//   held, and the next request is accepted once the walk has finished.
// ============================================================================
`default_nettype none

module fm_sound_register_to_channel_tone
    import fmtone_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_data,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer
    fmtone_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // Datapath
    fmtone_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // A report never overwrites one still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("report loaded over a pending one");

    // No new request taken right after a flush starts
    a_flush_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start_flush |=> !o_in_ready)
        else $error("request accepted during flush");

    // Update always follows the partner read
    a_exec_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> $past(w_cmd.rd_b))
        else $error("update without partner read");
`endif

endmodule

`default_nettype wire

FILE: dv/fm_sound_register_to_channel_tone_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// fm_sound_register_to_channel_tone_tb
// Self-checking bench for the FM channel tone register block. A driver feeds
// bus requests from a queue, a shadow copy of the register file and channel
// state predicts the channel reports, and a monitor checks them in order.
// Both sides insert random idle cycles; the receiver also holds off once for
// a long stretch so that the block backs up into its input.
// ============================================================================

module fm_sound_register_to_channel_tone_tb;
    import fmtone_pkg::*;

    localparam int        SETTLE_CYCLES  = 20;
    localparam int        HOLD_CYCLES    = 300;
    localparam int        WATCHDOG_LIMIT = 2000;
    localparam int        KEY_BIT        = 4;
    localparam int        DRUM_BIT       = 5;
    localparam logic [1:0] SYNC_SET      = 2'd1;
    localparam logic [1:0] SYNC_ODD      = 2'd3;

    // Bench signals; those driven by the bench are known from time zero
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_data   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_data  = 8'h00;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_data;

    // Shadow state of the block
    logic [7:0]  shadow_regs [REG_DEPTH];
    logic [12:0] ch_freq     [NUM_CH];
    logic [7:0]  ch_vol      [NUM_CH];
    logic [8:0]  dirty_mask;
    logic [5:0]  addr_latch;
    logic        sync_on;
    logic [7:0]  chan_base;

    t_in_item  pending_requests [$];
    t_out_item expected_reports [$];

    int fail_count  = 0;
    int tx_wait     = 0;
    int rx_wait     = 0;
    int rx_draw     = 0;
    int hold_left   = 0;
    int hold_token  = 0;
    int hold_seen   = 0;
    int idle_cycles = 0;
    bit tx_gaps_on  = 1'b1;
    bit rx_gaps_on  = 1'b1;

    fm_sound_register_to_channel_tone u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Channel state prediction
    // ------------------------------------------------------------------------
    function automatic void shadow_reset();
        int j;
        for (j = 0; j < REG_DEPTH; j++) shadow_regs[j] = 8'h00;
        for (j = 0; j < NUM_CH; j++) begin
            ch_freq[j] = '0;
            ch_vol[j]  = '0;
            shadow_regs[PAIR_FLIP + j] = ATT_INIT;
        end
        dirty_mask = '1;
        addr_latch = '0;
        sync_on    = 1'b0;
        chan_base  = 8'h00;
    endfunction

    // fnum is 9 bits, block 3 bits; result scaled down by 2^15
    function automatic logic [12:0] tone_for(logic [7:0] hi, logic [7:0] lo);
        logic [31:0] fnum;
        logic [31:0] prod;
        fnum = {23'd0, hi[0], lo};
        prod = (32'(TONE_MULT) * fnum) << hi[3:1];
        return 13'(prod >> 15);
    endfunction

    // Returns 1 when the write is stored
    function automatic bit store_register(logic [5:0] r, logic [7:0] v);
        logic [3:0] c;
        logic       drums;
        int         j;
        c     = r[3:0];
        drums = shadow_regs[REG_RHYTHM][DRUM_BIT];
        case (r[5:4])
            GRP_CTRL: begin
                if (c == CH_RHYTHM) begin
                    if (v == shadow_regs[r]) return 1'b0;
                    // drum mode off keeps only the top three bits
                    if (!v[DRUM_BIT]) v = v & 8'hE0;
                    // rising drum bit silences the drum channels
                    if (v[DRUM_BIT] && !shadow_regs[r][DRUM_BIT]) begin
                        for (j = DRUM_FIRST; j < NUM_CH; j++) ch_freq[j] = '0;
                        dirty_mask = dirty_mask | 9'h1C0;
                    end
                end
            end
            GRP_FLO: begin
                if (c > CH_LAST || v == shadow_regs[r]) return 1'b0;
                if ((!drums || c < DRUM_FIRST) && shadow_regs[r + 6'h10][KEY_BIT]) begin
                    ch_freq[c]    = tone_for(shadow_regs[r + 6'h10], v);
                    dirty_mask[c] = 1'b1;
                end
            end
            GRP_FHI: begin
                if (c > CH_LAST) return 1'b0;
                if (!drums || c < DRUM_FIRST) begin
                    ch_freq[c]    = v[KEY_BIT] ? tone_for(v, shadow_regs[r - 6'h10]) : '0;
                    dirty_mask[c] = 1'b1;
                end
            end
            default: begin
                if (c > CH_LAST || v == shadow_regs[r]) return 1'b0;
                if (v[3:0] != shadow_regs[r][3:0]) begin
                    ch_vol[c]     = 8'd17 * {4'h0, ~v[3:0]};
                    dirty_mask[c] = 1'b1;
                end
            end
        endcase
        shadow_regs[r] = v;
        return 1'b1;
    endfunction

    // One report per dirty channel, lowest first
    function automatic void emit_reports();
        t_out_item rec;
        int        j;
        for (j = 0; j < NUM_CH; j++) begin
            if (dirty_mask[j]) begin
                rec.sound_channel  = {1'b0, chan_base} + 9'(j);
                rec.tone_frequency = ch_freq[j];
                rec.tone_volume    = ch_vol[j];
                rec.last_of_run    = ((dirty_mask >> (j + 1)) == 0);
                expected_reports.push_back(rec);
            end
        end
        dirty_mask = '0;
    endfunction

    function automatic void apply_request(t_in_item req);
        bit stored;
        case (req.opcode)
            OP_LATCH: addr_latch = req.write_value[5:0];
            OP_SYNC: begin
                if (req.sync_mode != SYNC_KEEP) sync_on = (req.sync_mode != SYNC_ASYNC);
                emit_reports();
            end
            default: begin
                stored = store_register(req.opcode == OP_DATA ? addr_latch
                                                              : req.reg_address[5:0],
                                        req.write_value);
                // async mode flushes right after a stored write that leaves channels changed
                if (stored && !sync_on && dirty_mask != '0) emit_reports();
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_wait  <= 0;
        end else begin
            if (in_valid && o_in_ready) apply_request(in_data);
            if (!in_valid || o_in_ready) begin
                if (tx_wait != 0) begin
                    tx_wait  <= tx_wait - 1;
                    in_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    in_data  <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                    tx_wait  <= tx_gaps_on ? $urandom_range(0, 14) : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Report monitor and receiver pacing
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
            hold_left <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected report: channel %0d freq %0d vol %0d last %0b",
                           o_out_data.sound_channel, o_out_data.tone_frequency,
                           o_out_data.tone_volume, o_out_data.last_of_run);
                    fail_count++;
                end else begin
                    t_out_item want;
                    want = expected_reports.pop_front();
                    if (o_out_data.sound_channel !== want.sound_channel) begin
                        $error("sound_channel: expected %0d, got %0d",
                               want.sound_channel, o_out_data.sound_channel);
                        fail_count++;
                    end
                    if (o_out_data.tone_frequency !== want.tone_frequency) begin
                        $error("tone_frequency: expected %0d, got %0d",
                               want.tone_frequency, o_out_data.tone_frequency);
                        fail_count++;
                    end
                    if (o_out_data.tone_volume !== want.tone_volume) begin
                        $error("tone_volume: expected %0d, got %0d",
                               want.tone_volume, o_out_data.tone_volume);
                        fail_count++;
                    end
                    if (o_out_data.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, o_out_data.last_of_run);
                        fail_count++;
                    end
                end
            end
            // long hold-off first, then per-report stalls
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= (hold_left == 1);
            end else if (hold_token != hold_seen) begin
                hold_seen <= hold_token;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait   <= rx_wait - 1;
                out_ready <= (rx_wait == 1);
            end else if (o_out_valid && out_ready) begin
                rx_draw   = rx_gaps_on ? $urandom_range(0, 14) : 0;
                rx_wait   <= rx_draw;
                out_ready <= (rx_draw == 0);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: nothing moving on either side for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void put(t_opcode op, logic [7:0] addr, logic [7:0] val,
                                logic [1:0] mode);
        t_in_item req;
        req.opcode      = op;
        req.reg_address = addr;
        req.write_value = val;
        req.sync_mode   = mode;
        pending_requests.push_back(req);
    endfunction

    // Mostly channel registers and the rhythm register
    function automatic logic [5:0] pick_register();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) return REG_RHYTHM;
        if (k < 5)  return 6'h10 + 6'($urandom_range(0, 8));
        if (k < 9)  return 6'h20 + 6'($urandom_range(0, 8));
        if (k < 13) return PAIR_FLIP + 6'($urandom_range(0, 8));
        return 6'($urandom_range(0, 63));
    endfunction

    // Returns the number of requests queued
    function automatic int put_random();
        int         kind;
        logic [5:0] r;
        r    = pick_register();
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            put(OP_DIRECT, {2'($urandom_range(0, 3)), r}, 8'($urandom_range(0, 255)),
                2'($urandom_range(0, 3)));
            return 1;
        end
        if (kind < 80) begin
            put(OP_LATCH, 8'($urandom_range(0, 255)), {2'($urandom_range(0, 3)), r},
                2'($urandom_range(0, 3)));
            put(OP_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                2'($urandom_range(0, 3)));
            return 2;
        end
        if (kind < 92) begin
            put(OP_SYNC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                2'($urandom_range(0, 3)));
            return 1;
        end
        // noise: data write through whatever the latch holds, or fully random
        put(t_opcode'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
        return 1;
    endfunction

    task automatic put_random_batch(input int count);
        int n;
        n = 0;
        while (n < count) n += put_random();
    endtask

    // Everything sent and reported, then let a reportless write finish
    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_valid || expected_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_chan_base(input logic [7:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        chan_base = val;
        @(negedge clk);
    endtask

    initial begin
        shadow_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        wait_drained();
        write_chan_base(8'h00);

        // Directed requests
        put(OP_DIRECT, 8'h10, 8'hFF, SYNC_ASYNC);  // key off: all nine from reset
        put(OP_DIRECT, 8'h20, 8'h3F, SYNC_ASYNC);  // highest tone
        put(OP_LATCH,  8'h00, 8'hF1, SYNC_ODD);    // latch keeps low six bits
        put(OP_DATA,   8'hFF, 8'h00, SYNC_SET);    // loudest volume
        put(OP_DATA,   8'h00, 8'hF0, SYNC_KEEP);   // same attenuation, stored only
        put(OP_DIRECT, 8'h10, 8'hFF, SYNC_ASYNC);  // unchanged value
        put(OP_DIRECT, 8'h19, 8'h55, SYNC_ASYNC);  // channel nine and above
        put(OP_DIRECT, 8'hEF, 8'h12, SYNC_ASYNC);
        put(OP_DIRECT, 8'h7C, 8'hAA, SYNC_ASYNC);
        put(OP_DIRECT, 8'hC7, 8'hAA, SYNC_ASYNC);  // plain register
        put(OP_DIRECT, 8'h0E, 8'h1F, SYNC_ASYNC);  // drum off clears low bits
        put(OP_DIRECT, 8'h12, 8'h40, SYNC_ASYNC);  // low byte with key off
        put(OP_DIRECT, 8'h26, 8'h15, SYNC_ASYNC);
        put(OP_DIRECT, 8'h28, 8'h1E, SYNC_ASYNC);
        put(OP_DIRECT, 8'h0E, 8'h3F, SYNC_ASYNC);  // drum on mutes 6..8
        put(OP_DIRECT, 8'h27, 8'h13, SYNC_ASYNC);  // drum channel, no tone change
        put(OP_DIRECT, 8'h16, 8'h80, SYNC_ASYNC);
        put(OP_SYNC,   8'h00, 8'h00, SYNC_SET);    // empty flush
        put(OP_DIRECT, 8'h21, 8'h11, SYNC_ASYNC);
        put(OP_DIRECT, 8'h11, 8'h01, SYNC_ASYNC);
        put(OP_DIRECT, 8'h38, 8'h03, SYNC_ASYNC);
        put(OP_SYNC,   8'hFF, 8'h00, SYNC_KEEP);
        put(OP_SYNC,   8'h00, 8'hFF, SYNC_ODD);    // odd mode acts as sync
        put(OP_DIRECT, 8'h0E, 8'h00, SYNC_ASYNC);
        put(OP_SYNC,   8'h00, 8'hFF, SYNC_ASYNC);
        wait_drained();

        // Top offset, no idling on the sender, one long receiver hold
        write_chan_base(8'hFF);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hold_token <= hold_token + 1;
        put(OP_DIRECT, 8'h28, 8'h1F, SYNC_ASYNC);
        put_random_batch(55);
        wait_drained();

        // Mid offset, idling on both sides, a full drain halfway
        write_chan_base(8'($urandom_range(1, 254)));
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        put_random_batch(30);
        wait_drained();
        put_random_batch(30);
        wait_drained();

        // Sender idles, receiver always ready
        write_chan_base(8'hF7);
        rx_gaps_on = 1'b0;
        put_random_batch(30);
        wait_drained();

        if (expected_reports.size() != 0) begin
            $error("%0d reports never arrived", expected_reports.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
